FILE: src/spq_pkg.sv
package spq_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int CLASS_DEPTH_DEFAULT = 16;
   localparam int ID_WIDTH = 16;
   localparam int COUNT_WIDTH = 7;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [1:0]          prio_class;
      logic [ID_WIDTH-1:0] entry_id;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [ID_WIDTH-1:0]    out_entry_id;
      logic [1:0]             out_class;
      logic [COUNT_WIDTH-1:0] total_count;
      logic                   all_empty;
   } rsp_type;

endpackage

FILE: src/spq_front.sv
module spq_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_kind,
   input  logic [1:0]                   in_class,
   input  logic [spq_pkg::ID_WIDTH-1:0] in_id,
   output logic                         q_valid,
   input  logic                         q_ready,
   output logic                         q_kind,
   output logic [1:0]                   q_class,
   output logic [spq_pkg::ID_WIDTH-1:0] q_id
);
   import spq_pkg::*;

   // two-entry queue between front and back
   logic [1:0]          cnt_ff, cnt_in;
   logic                rd_ff, rd_in;
   logic                wr_ff, wr_in;
   logic                kind_ff [2];
   logic [1:0]          class_ff [2];
   logic [ID_WIDTH-1:0] id_ff [2];
   logic                push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_kind   = kind_ff[rd_ff];
   assign q_class  = class_ff[rd_ff];
   assign q_id     = id_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) begin
         kind_ff[wr_ff]  <= in_kind;
         class_ff[wr_ff] <= in_class;
         id_ff[wr_ff]    <= in_id;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("front queue overflow");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("front queue pointers inconsistent");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push)
      else $error("push into full front queue");
endmodule

FILE: src/spq_back.sv
module spq_back #(
   parameter int CLASS_DEPTH = spq_pkg::CLASS_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  logic                         q_kind,
   input  logic [1:0]                   q_class,
   input  logic [spq_pkg::ID_WIDTH-1:0] q_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [spq_pkg::ID_WIDTH-1:0] rsp_id,
   output logic [1:0]                   rsp_class,
   output logic [spq_pkg::COUNT_WIDTH-1:0] rsp_total,
   output logic                         rsp_empty
);
   import spq_pkg::*;

   localparam int PW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int CW = $clog2(CLASS_DEPTH + 1);
   localparam int TW = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);
   localparam int AW = PW + 2;

   logic [ID_WIDTH-1:0] mem [NUM_CLASSES * (2 ** PW)];
   logic [PW-1:0] head_ff [NUM_CLASSES];
   logic [PW-1:0] tail_ff [NUM_CLASSES];
   logic [CW-1:0] count_ff [NUM_CLASSES];
   logic [TW-1:0] total_ff;

   // stage 1: decision; stage 2 (output reg) collects memory read
   logic          s_valid_ff, s_valid_in;
   logic [1:0]    s_status_ff;
   logic          s_fromMem_ff;
   logic [ID_WIDTH-1:0] s_id_ff;
   logic [1:0]    s_class_ff;
   logic [TW-1:0] s_total_ff;
   logic [ID_WIDTH-1:0] rdata_ff;

   logic          take, enq, deq, full, found;
   logic [1:0]    pick;
   logic [AW-1:0] waddr, raddr;
   logic [TW-1:0] total_in;

   assign q_ready = !s_valid_ff || rsp_ready;
   assign take    = q_valid && q_ready;
   assign full    = (count_ff[q_class] == CW'(CLASS_DEPTH));

   always_comb begin
      found = 1'b0;
      pick  = 2'd0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (count_ff[c] != '0) begin
            found = 1'b1;
            pick  = 2'(c);
         end
      end
   end

   assign enq   = take && (q_kind == OP_ENQ) && !full;
   assign deq   = take && (q_kind == OP_DEQ) && found;
   assign waddr = {q_class, tail_ff[q_class]};
   assign raddr = {pick, head_ff[pick]};
   assign total_in = total_ff + TW'(enq) - TW'(deq);
   assign s_valid_in = take || (s_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (enq) mem[waddr] <= q_id;
      if (deq) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         total_ff   <= '0;
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         total_ff   <= total_in;
         if (enq) begin
            tail_ff[q_class]  <= (tail_ff[q_class] == PW'(CLASS_DEPTH - 1)) ? '0
                                 : tail_ff[q_class] + 1'b1;
            count_ff[q_class] <= count_ff[q_class] + 1'b1;
         end
         if (deq) begin
            head_ff[pick]  <= (head_ff[pick] == PW'(CLASS_DEPTH - 1)) ? '0
                              : head_ff[pick] + 1'b1;
            count_ff[pick] <= count_ff[pick] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_total_ff   <= total_in;
         s_fromMem_ff <= deq;
         if (q_kind == OP_ENQ) begin
            s_status_ff <= full ? ST_FULL : ST_OK;
            s_id_ff     <= full ? '0 : q_id;
            s_class_ff  <= q_class;
         end else begin
            s_status_ff <= found ? ST_OK : ST_EMPTY;
            s_id_ff     <= '0;
            s_class_ff  <= found ? pick : 2'd0;
         end
      end
   end

   assign rsp_valid  = s_valid_ff;
   assign rsp_status = s_status_ff;
   assign rsp_id     = s_fromMem_ff ? rdata_ff : s_id_ff;
   assign rsp_class  = s_class_ff;
   assign rsp_total  = COUNT_WIDTH'(s_total_ff);
   assign rsp_empty  = (s_total_ff == '0);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !take)
      else $error("result overwritten while stalled");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_id)
         && $stable(rsp_class) && $stable(rsp_total))
      else $error("result changed while stalled");
   a_one_op: assert property (@(posedge clock) disable iff (reset) !(enq && deq))
      else $error("enqueue and dequeue in one cycle");
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff == TW'(count_ff[0]) + TW'(count_ff[1]) + TW'(count_ff[2]) + TW'(count_ff[3]))
      else $error("total count mismatch");
endmodule

FILE: src/strict_priority_four_class_queue.sv
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req_data  (kind, prio_class, entry_id)
// result  | rsp_valid | rsp_ready | rsp_data  (status, out_entry_id, out_class,
//         |           |           |            total_count, all_empty)
// One operation per cycle sustained while rsp_ready is high; each operation goes
// through the input queue, then the decision stage with its registered entry-store read.
// Synchronous active-high reset clears pointers and counts; the store is not cleared.
// A stalled result holds the back stage; the two-entry input queue then fills.
module strict_priority_four_class_queue #(
   parameter int CLASS_DEPTH = spq_pkg::CLASS_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   logic                   q_valid, q_ready, q_kind;
   logic [1:0]             q_class;
   logic [ID_WIDTH-1:0]    q_id;
   logic [1:0]             b_status;
   logic [ID_WIDTH-1:0]    b_id;
   logic [1:0]             b_class;
   logic [COUNT_WIDTH-1:0] b_total;
   logic                   b_empty;

   spq_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .in_kind(req_data.kind), .in_class(req_data.prio_class),
      .in_id(req_data.entry_id),
      .q_valid, .q_ready, .q_kind, .q_class, .q_id
   );

   spq_back #(.CLASS_DEPTH(CLASS_DEPTH)) u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_kind, .q_class, .q_id,
      .rsp_valid, .rsp_ready,
      .rsp_status(b_status), .rsp_id(b_id), .rsp_class(b_class),
      .rsp_total(b_total), .rsp_empty(b_empty)
   );

   assign rsp_data = {b_status, b_id, b_class, b_total, b_empty};
endmodule

FILE: bench/testbench.sv
module testbench;
   import spq_pkg::*;

   localparam int DEPTH = CLASS_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   strict_priority_four_class_queue u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // shadow queues per class
   logic [ID_WIDTH-1:0] class_fifo[NUM_CLASSES][$];
   rsp_type pending_results[$];
   int errors = 0;
   int transfers_in = 0;
   int transfers_out = 0;
   int full_hits = 0;
   int empty_hits = 0;
   int idle_cycles = 0;
   bit send_gaps = 1'b1;
   bit drain_stalls = 1'b1;

   function automatic int held_total();
      int n;
      n = 0;
      for (int c = 0; c < NUM_CLASSES; c++) n += class_fifo[c].size();
      return n;
   endfunction

   function automatic rsp_type predict_queue_op(kind_type op, logic [1:0] cls,
                                                logic [ID_WIDTH-1:0] id);
      rsp_type r;
      r = '0;
      r.status = ST_OK;
      if (op == OP_ENQ) begin
         r.out_class = cls;
         if (class_fifo[cls].size() >= DEPTH) begin
            r.status = ST_FULL;
            full_hits++;
         end else begin
            class_fifo[cls].push_back(id);
            r.out_entry_id = id;
         end
      end else begin
         r.status = ST_EMPTY;
         for (int c = 0; c < NUM_CLASSES; c++) begin
            if (r.status == ST_EMPTY && class_fifo[c].size() != 0) begin
               r.status = ST_OK;
               r.out_entry_id = class_fifo[c].pop_front();
               r.out_class = c[1:0];
            end
         end
         if (r.status == ST_EMPTY) empty_hits++;
      end
      r.total_count = COUNT_WIDTH'(held_total());
      r.all_empty = (held_total() == 0);
      return r;
   endfunction

   task automatic send_op(kind_type op, logic [1:0] cls, logic [ID_WIDTH-1:0] id);
      int gap;
      req_type item;
      item.kind = op;
      item.prio_class = cls;
      item.entry_id = id;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_queue_op(op, cls, id));
      transfers_in++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result stalls
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         if (drain_stalls && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         transfers_out++;
         if (pending_results.size() == 0) begin
            $error("unexpected transfer on result channel");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status); errors++;
            end
            if (rsp_data.out_entry_id !== want.out_entry_id) begin
               $error("out_entry_id exp %0h got %0h", want.out_entry_id,
                      rsp_data.out_entry_id);
               errors++;
            end
            if (rsp_data.out_class !== want.out_class) begin
               $error("out_class exp %0d got %0d", want.out_class, rsp_data.out_class);
               errors++;
            end
            if (rsp_data.total_count !== want.total_count) begin
               $error("total_count exp %0d got %0d", want.total_count,
                      rsp_data.total_count);
               errors++;
            end
            if (rsp_data.all_empty !== want.all_empty) begin
               $error("all_empty exp %0b got %0b", want.all_empty, rsp_data.all_empty);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic test_directed();
      send_op(OP_DEQ, 2'd0, 16'hFFFF);
      send_op(OP_ENQ, 2'd3, 16'hFFFF);
      send_op(OP_ENQ, 2'd2, 16'h0000);
      send_op(OP_ENQ, 2'd1, 16'hA5A5);
      send_op(OP_ENQ, 2'd0, 16'h5A5A);
      send_op(OP_ENQ, 2'd0, 16'h0001);
      for (int i = 0; i < 6; i++) send_op(OP_DEQ, 2'($urandom), 16'($urandom));
   endtask

   // fill every class past full, then drain; wraps the rings too
   task automatic test_full_and_wrap();
      for (int c = 0; c < NUM_CLASSES; c++)
         for (int i = 0; i < DEPTH + 2; i++) send_op(OP_ENQ, c[1:0], 16'($urandom));
      for (int i = 0; i < NUM_CLASSES * DEPTH + 2; i++) send_op(OP_DEQ, 2'd0, 16'($urandom));
   endtask

   task automatic test_paused_sender();
      for (int i = 0; i < 5; i++) send_op(OP_ENQ, 2'($urandom), 16'($urandom));
      wait_drained();
      for (int i = 0; i < 6; i++) send_op(OP_DEQ, 2'd0, 16'($urandom));
   endtask

   task automatic test_random(int count);
      int bias;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) bias = $urandom_range(20, 80);
         send_op(kind_type'(($urandom_range(0, 99) < bias) ? OP_ENQ : OP_DEQ),
                 2'($urandom), 16'($urandom));
      end
   endtask

   task automatic test_no_idling(int count);
      send_gaps = 1'b0;
      drain_stalls = 1'b0;
      test_random(count);
   endtask

   initial begin
      int spin;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_and_wrap();
      test_paused_sender();
      test_random(1300);
      test_no_idling(250);
      req_valid <= 1'b0;
      spin = 0;
      while (pending_results.size() != 0 && spin < WATCHDOG_LIMIT) begin
         @(posedge clock);
         spin++;
      end
      repeat (6) @(posedge clock);
      $display("Sent %0d operations, checked %0d results.", transfers_in, transfers_out);
      $display("Hit full class %0d times and empty dequeue %0d times.",
               full_hits, empty_hits);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         if (pending_results.size() != 0)
            $error("%0d results never arrived", pending_results.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
